@@ rtl/square_wave_sync_detector_top_defines.svh @@
// ----------------------------------------------------------------------------
// Square-wave sync detector: assertion macros
// Shared concurrent-assertion forms, clocked on aclk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef SQUARE_WAVE_SYNC_DETECTOR_TOP_DEFINES_SVH
`define SQUARE_WAVE_SYNC_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication
`define SWSD_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (conseq)) else $error(msg);

// next-cycle implication
`define SWSD_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (conseq)) else $error(msg);

`endif

@@ rtl/swsd_pkg.sv @@
// ----------------------------------------------------------------------------
// swsd_pkg
// Types and constants shared by the square-wave sync detector modules.
// ----------------------------------------------------------------------------
package swsd_pkg;

    localparam int BUFFER_SAMPLES = 128;

    localparam int SAMPLE_W  = 12;
    localparam int PHASE_W   = 32;
    localparam int STEP_W    = PHASE_W - 1;
    localparam int OFFSET_W  = 39;
    localparam int LIMIT_W   = $clog2(BUFFER_SAMPLES / 2);
    localparam int LIMIT_LSB = PHASE_W - LIMIT_W;
    localparam int SUM_W     = 21;
    localparam int COUNT_W   = 8;
    localparam int AVG_W     = 29;

    // divider: |sum| * 1024 / count, then * 64
    localparam int PRESCALE_SH = 10;
    localparam int FRAC_SH     = 6;
    localparam int DIVIDEND_W  = SUM_W + PRESCALE_SH;
    localparam int QUOT_W      = AVG_W - FRAC_SH;
    localparam int DIV_STEPS   = DIVIDEND_W;
    localparam int DSTEP_W     = $clog2(DIV_STEPS);

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 72;
    localparam int S_PAD_W   = S_TDATA_W - SAMPLE_W - PHASE_W;
    localparam int M_PAD_W   = M_TDATA_W - 2 * AVG_W - COUNT_W;

    localparam logic [PHASE_W-1:0] TX_STEP_RESET = 32'd67108864;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_LOAD,
        ST_DIV,
        ST_HOLD
    } swsd_state_t;

    typedef struct packed {
        logic accum;
        logic div_load;
        logic div_step;
        logic out_load;
    } swsd_cmd_t;

endpackage

@@ rtl/swsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// swsd_ctrl
// Sequencer: accumulate, load divider, run divider steps, hand off result.
// ----------------------------------------------------------------------------
`include "square_wave_sync_detector_top_defines.svh"

module swsd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    input  logic               m_tready,
    output logic               m_tvalid,
    output swsd_pkg::swsd_cmd_t cmd
);
    import swsd_pkg::*;

    swsd_state_t            state_reg, state_next;
    logic [DSTEP_W-1:0]     step_cnt_reg, step_cnt_next;
    logic                   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCUM;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM: begin
                if (cmd.accum && s_tlast) state_next = ST_LOAD;
            end
            ST_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (step_cnt_reg == DSTEP_W'(DIV_STEPS - 1)) state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (cmd.out_load) state_next = ST_ACCUM;
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == ST_ACCUM);
        cmd.accum    = s_tvalid && (state_reg == ST_ACCUM);
        cmd.div_load = (state_reg == ST_LOAD);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.out_load = (state_reg == ST_HOLD) && (!out_valid_reg || m_tready);

        step_cnt_next = step_cnt_reg;
        if (cmd.div_load) begin
            step_cnt_next = '0;
        end else if (cmd.div_step) begin
            step_cnt_next = step_cnt_reg + DSTEP_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    `SWSD_ASSERT_NEXT(a_last_starts_div, cmd.accum && s_tlast, state_reg == ST_LOAD,
        "last item did not start the divider")
    `SWSD_ASSERT_NOW(a_step_range, state_reg == ST_DIV, step_cnt_reg < DSTEP_W'(DIV_STEPS),
        "divider step count out of range")
    `SWSD_ASSERT_NEXT(a_div_ends, state_reg == ST_DIV && step_cnt_reg == DSTEP_W'(DIV_STEPS - 1),
        state_reg == ST_HOLD, "divider did not finish after its last step")
    `SWSD_ASSERT_NEXT(a_out_load_valid, cmd.out_load, m_tvalid && s_tready,
        "result load did not raise valid and reopen input")

endmodule

@@ rtl/swsd_div.sv @@
// ----------------------------------------------------------------------------
// swsd_div
// Restoring divider, one quotient bit per cycle while step high, signed 13.16.
// ----------------------------------------------------------------------------
module swsd_div (
    input  logic                                aclk,
    input  logic                                load,
    input  logic                                step,
    input  logic [swsd_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic                                negative,
    input  logic [swsd_pkg::COUNT_W-1:0]        divisor,
    output logic signed [swsd_pkg::AVG_W-1:0]   avg
);
    import swsd_pkg::*;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [COUNT_W-1:0]    rem_reg, rem_next;
    logic [COUNT_W-1:0]    div_reg;
    logic                  neg_reg;
    logic [COUNT_W:0]      trial;
    logic                  fits;
    logic [QUOT_W-1:0]     q_mag;
    logic [QUOT_W-1:0]     q_signed;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? COUNT_W'(trial - {1'b0, div_reg}) : trial[COUNT_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
        q_mag    = quo_reg[QUOT_W-1:0];
        q_signed = neg_reg ? (QUOT_W'(0) - q_mag) : q_mag;
        avg      = {q_signed, FRAC_SH'(0)};
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= negative;
        end else if (step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule

@@ rtl/swsd_dp.sv @@
// ----------------------------------------------------------------------------
// swsd_dp
// Phase accumulator, quadrant sums, divider pair and result register.
// ----------------------------------------------------------------------------
module swsd_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  swsd_pkg::swsd_cmd_t                 cmd,
    input  logic                                cfg_we,
    input  logic [swsd_pkg::PHASE_W-1:0]        cfg_wdata,
    input  logic [swsd_pkg::SAMPLE_W-1:0]       sample,
    input  logic [swsd_pkg::PHASE_W-1:0]        start_phase,
    input  logic                                first,
    output logic [swsd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser
);
    import swsd_pkg::*;

    logic [PHASE_W-1:0]       tx_reg;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic [OFFSET_W-1:0]      offset_reg, offset_next;
    logic [LIMIT_W-1:0]       limit_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [SUM_W-1:0]  sum_i_reg, sum_i_next;
    logic signed [SUM_W-1:0]  sum_q_reg, sum_q_next;
    logic [COUNT_W-1:0]       count_reg, count_next;

    logic [PHASE_W-1:0]       eff_phase;
    logic [STEP_W-1:0]        eff_step;
    logic [LIMIT_W-1:0]       eff_limit;
    logic [OFFSET_W-1:0]      eff_offset;
    logic [COUNT_W-1:0]       eff_count;
    logic signed [SUM_W-1:0]  eff_i, eff_q;
    logic signed [SUM_W-1:0]  s_ext;
    logic                     take;
    logic                     neg_i, neg_q;

    logic [SUM_W-1:0]         abs_i, abs_q;
    logic signed [AVG_W-1:0]  avg_i, avg_q;
    logic [COUNT_W-1:0]       div_cnt_reg;

    logic signed [AVG_W-1:0]  out_i_reg, out_q_reg;
    logic [COUNT_W-1:0]       out_cnt_reg;
    logic                     out_nfp_reg;

    always_comb begin
        eff_phase  = first ? start_phase + {2'b00, tx_reg[PHASE_W-1:2]} : phase_reg;
        eff_step   = first ? tx_reg[PHASE_W-1:1] : step_reg;
        eff_limit  = first ? tx_reg[PHASE_W-1:LIMIT_LSB] : limit_reg;
        eff_offset = first ? '0 : offset_reg;
        eff_count  = first ? '0 : count_reg;
        eff_i      = first ? '0 : sum_i_reg;
        eff_q      = first ? '0 : sum_q_reg;

        take  = (eff_count < COUNT_W'(BUFFER_SAMPLES))
             && (eff_offset[OFFSET_W-1:PHASE_W] < (OFFSET_W-PHASE_W)'(eff_limit));
        s_ext = $signed({(SUM_W-SAMPLE_W)'(0), sample});
        neg_i = eff_phase[PHASE_W-1] ^ eff_phase[PHASE_W-2];
        neg_q = eff_phase[PHASE_W-1];

        sum_i_next  = eff_i;
        sum_q_next  = eff_q;
        phase_next  = eff_phase;
        offset_next = eff_offset;
        count_next  = eff_count;
        if (take) begin
            sum_i_next  = neg_i ? eff_i - s_ext : eff_i + s_ext;
            sum_q_next  = neg_q ? eff_q - s_ext : eff_q + s_ext;
            phase_next  = eff_phase + {1'b0, eff_step};
            offset_next = eff_offset + OFFSET_W'(eff_step);
            count_next  = eff_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_reg     <= TX_STEP_RESET;
            phase_reg  <= '0;
            offset_reg <= '0;
            limit_reg  <= '0;
            step_reg   <= '0;
            sum_i_reg  <= '0;
            sum_q_reg  <= '0;
            count_reg  <= '0;
        end else begin
            if (cfg_we) begin
                tx_reg <= cfg_wdata;
            end
            if (cmd.accum) begin
                phase_reg  <= phase_next;
                offset_reg <= offset_next;
                limit_reg  <= eff_limit;
                step_reg   <= eff_step;
                sum_i_reg  <= sum_i_next;
                sum_q_reg  <= sum_q_next;
                count_reg  <= count_next;
            end
        end
    end

    assign abs_i = sum_i_reg[SUM_W-1] ? SUM_W'(0) - sum_i_reg : sum_i_reg;
    assign abs_q = sum_q_reg[SUM_W-1] ? SUM_W'(0) - sum_q_reg : sum_q_reg;

    swsd_div u_div_i (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend ({abs_i, PRESCALE_SH'(0)}),
        .negative (sum_i_reg[SUM_W-1]),
        .divisor  (count_reg),
        .avg      (avg_i)
    );

    swsd_div u_div_q (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend ({abs_q, PRESCALE_SH'(0)}),
        .negative (sum_q_reg[SUM_W-1]),
        .divisor  (count_reg),
        .avg      (avg_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            div_cnt_reg <= count_reg;
        end
        if (cmd.out_load) begin
            out_i_reg   <= (div_cnt_reg == '0) ? '0 : avg_i;
            out_q_reg   <= (div_cnt_reg == '0) ? '0 : avg_q;
            out_cnt_reg <= div_cnt_reg;
            out_nfp_reg <= (div_cnt_reg == '0);
        end
    end

    assign m_tdata = {M_PAD_W'(0), out_cnt_reg, out_q_reg, out_i_reg};
    assign m_tuser = out_nfp_reg;

endmodule

@@ rtl/square_wave_sync_detector_top.sv @@
// ----------------------------------------------------------------------------
// square_wave_sync_detector_top
// Quadrature square-wave synchronous detector over one ADC buffer.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one ADC sample per item; tuser marks the first item of
//   a buffer (restarts phase and sums, reads start_phase), tlast the last.
//   m_ channel returns one item per buffer: both averages in signed 13.16,
//   the used sample count, and tuser set when no full period fit.
//   cfg_we/cfg_wdata write tx_phase_step; it takes effect at the next first.
// Throughput: one sample item per cycle while a buffer streams in.
// Result: the last item is followed by a divider load and 31 divider steps
//   (one quotient bit per cycle per sum, restoring divider pair); the result
//   is then written to the output register, which drives m_tvalid. s_tready
//   stays low over that time and returns together with m_tvalid.
// Stall: the result sits in an output register; while the receiver holds
//   m_tready low, input reopens as soon as the register is loaded, and a
//   later result waits in the divider until the register is free.
// Reset: aresetn (sync, low) clears state and sums; tx_phase_step = 2^26.
// ----------------------------------------------------------------------------
module square_wave_sync_detector_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [swsd_pkg::PHASE_W-1:0]       cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [swsd_pkg::S_TDATA_W-1:0]     s_tdata,  // sample[11:0], start_phase[43:12]
    input  logic                               s_tuser,  // first
    input  logic                               s_tlast,  // last
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [swsd_pkg::M_TDATA_W-1:0]     m_tdata,  // in_phase_avg[28:0],
                                                         // quadrature_avg[57:29],
                                                         // used_count[65:58]
    output logic                               m_tuser   // no_full_period
);
    import swsd_pkg::*;

    swsd_cmd_t cmd;

    swsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    swsd_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .sample      (s_tdata[SAMPLE_W-1:0]),
        .start_phase (s_tdata[SAMPLE_W+PHASE_W-1:SAMPLE_W]),
        .first       (s_tuser),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
